/* hdl/rmq_pkg.sv */
// Shared constants and types for the rotation-matrix-to-quaternion block.
package rmq_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

	// Which component carries the square root.
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2,
		AXIS_W = 2'd3
	} axis_t;

	// Control word that travels with each transaction down the cell chain.
	typedef struct packed {
		logic       ok;
		axis_t      best;
		logic [2:0] neg;
	} ctl_t;

endpackage

/* hdl/rmq_if.sv */
// Valid/ready channel interfaces for matrix input and quaternion output.
interface rmq_in_if #(parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;

	modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
		input ready);
	modport sink (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
		output ready);
endinterface

interface rmq_out_if #(parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] quat_x, quat_y, quat_z, quat_w;
	logic ok;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, ok, input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, ok, output ready);
endinterface

/* hdl/rmq_front.sv */
// Front cell: candidates, pivot choice, off-diagonal terms, radicand.
module rmq_front #(
	parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rmq_in_if.sink in_ch,
	output logic out_valid,
	input  logic out_ready,
	output rmq_pkg::ctl_t out_ctl,
	output logic [3*(DATA_WIDTH+1)-1:0] out_mag,
	output logic [2*((((DATA_WIDTH > FRAC_BITS+1) ? DATA_WIDTH : FRAC_BITS+1)
		+ FRAC_BITS + 2) / 2)-1:0] out_nr
);
	localparam int CW = ((DATA_WIDTH > FRAC_BITS+1) ? DATA_WIDTH : FRAC_BITS+1) + 3;
	localparam int SQ = (CW + FRAC_BITS - 1) / 2;
	localparam int MW = DATA_WIDTH + 1;

	logic signed [CW-1:0] one, e11, e22, e33, cx, cy, cz, cw, cbest;
	logic signed [MW-1:0] dxy, dxz, dyz, wx, wy, wz;
	logic signed [MW-1:0] d [3];
	logic [MW-1:0] mag [3];
	logic [2*SQ-1:0] cext;
	rmq_pkg::axis_t best;
	rmq_pkg::ctl_t ctl_n;
	logic valid_q;

	always_comb begin
		one = {{(CW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
		e11 = CW'(in_ch.m11);
		e22 = CW'(in_ch.m22);
		e33 = CW'(in_ch.m33);
		cx = one + e11 - e22 - e33;
		cy = one - e11 + e22 - e33;
		cz = one - e11 - e22 + e33;
		cw = one + e11 + e22 + e33;
		// strict compares keep the earliest candidate on a tie
		best = rmq_pkg::AXIS_X;
		cbest = cx;
		if (cy > cbest) begin
			best = rmq_pkg::AXIS_Y;
			cbest = cy;
		end
		if (cz > cbest) begin
			best = rmq_pkg::AXIS_Z;
			cbest = cz;
		end
		if (cw > cbest) begin
			best = rmq_pkg::AXIS_W;
			cbest = cw;
		end
		dxy = MW'(in_ch.m12) + MW'(in_ch.m21);
		dxz = MW'(in_ch.m31) + MW'(in_ch.m13);
		dyz = MW'(in_ch.m23) + MW'(in_ch.m32);
		wx  = MW'(in_ch.m32) - MW'(in_ch.m23);
		wy  = MW'(in_ch.m13) - MW'(in_ch.m31);
		wz  = MW'(in_ch.m21) - MW'(in_ch.m12);
		unique case (best)
			rmq_pkg::AXIS_X: begin
				d[0] = dxy; d[1] = dxz; d[2] = wx;
			end
			rmq_pkg::AXIS_Y: begin
				d[0] = dxy; d[1] = dyz; d[2] = wy;
			end
			rmq_pkg::AXIS_Z: begin
				d[0] = dxz; d[1] = dyz; d[2] = wz;
			end
			default: begin
				d[0] = wx; d[1] = wy; d[2] = wz;
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			ctl_n.neg[i] = d[i][MW-1];
			mag[i] = d[i][MW-1] ? MW'(-d[i]) : MW'(d[i]);
		end
		ctl_n.ok = !cbest[CW-1];
		ctl_n.best = best;
		cext = ctl_n.ok ? (2*SQ)'($unsigned(cbest)) : '0;
	end

	assign in_ch.ready = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready) begin
			out_ctl <= ctl_n;
			out_mag <= {mag[2], mag[1], mag[0]};
			out_nr  <= cext << (FRAC_BITS - 2);
		end
	end
endmodule

/* hdl/rmq_sqrt_cell.sv */
// Square-root cell: one result bit of the restoring integer square root.
module rmq_sqrt_cell #(
	parameter int SQ = 16,
	parameter int PW = 51
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rmq_pkg::ctl_t in_ctl,
	input  logic [PW-1:0] in_pay,
	input  logic [2*SQ-1:0] in_nr,
	input  logic [SQ-1:0] in_root,
	input  logic [SQ+1:0] in_rem,
	output logic out_valid,
	input  logic out_ready,
	output rmq_pkg::ctl_t out_ctl,
	output logic [PW-1:0] out_pay,
	output logic [2*SQ-1:0] out_nr,
	output logic [SQ-1:0] out_root,
	output logic [SQ+1:0] out_rem
);
	localparam int RW = SQ + 2;

	logic [RW+1:0] rem_sh, trial;
	logic [SQ-1:0] root_n;
	logic [RW-1:0] rem_n;
	logic valid_q;

	always_comb begin
		rem_sh = {in_rem, in_nr[2*SQ-1 -: 2]};
		trial = (RW+2)'({in_root, 2'b01});
		if (rem_sh >= trial) begin
			rem_n = RW'(rem_sh - trial);
			root_n = {in_root[SQ-2:0], 1'b1};
		end else begin
			rem_n = rem_sh[RW-1:0];
			root_n = {in_root[SQ-2:0], 1'b0};
		end
	end

	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			out_ctl  <= in_ctl;
			out_pay  <= in_pay;
			out_nr   <= in_nr << 2;
			out_root <= root_n;
			out_rem  <= rem_n;
		end
	end
endmodule

/* hdl/rmq_div_cell.sv */
// Divider cell: one quotient bit for each of three restoring-division lanes.
module rmq_div_cell #(
	parameter int SQ = 16,
	parameter int NW = 31
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rmq_pkg::ctl_t in_ctl,
	input  logic [SQ-1:0] in_root,
	input  logic [2:0][NW-1:0] in_nq,
	input  logic [2:0][SQ+1:0] in_rem,
	output logic out_valid,
	input  logic out_ready,
	output rmq_pkg::ctl_t out_ctl,
	output logic [SQ-1:0] out_root,
	output logic [2:0][NW-1:0] out_nq,
	output logic [2:0][SQ+1:0] out_rem
);
	localparam int DW = SQ + 2;

	logic [DW:0] dvs;
	logic [DW:0] rem_sh [3];
	logic [2:0][NW-1:0] nq_n;
	logic [2:0][DW-1:0] rem_n;
	logic valid_q;

	// numerator bits leave at the top while quotient bits enter at the bottom
	always_comb begin
		dvs = (DW+1)'({in_root, 2'b00});
		for (int i = 0; i < 3; i++) begin
			rem_sh[i] = {in_rem[i], in_nq[i][NW-1]};
			if (rem_sh[i] >= dvs) begin
				rem_n[i] = DW'(rem_sh[i] - dvs);
				nq_n[i] = {in_nq[i][NW-2:0], 1'b1};
			end else begin
				rem_n[i] = rem_sh[i][DW-1:0];
				nq_n[i] = {in_nq[i][NW-2:0], 1'b0};
			end
		end
	end

	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			out_ctl  <= in_ctl;
			out_root <= in_root;
			out_nq   <= nq_n;
			out_rem  <= rem_n;
		end
	end
endmodule

/* hdl/rmq_back.sv */
// Back cell: saturation, component placement and the output register.
module rmq_back #(
	parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
	parameter int SQ = 16,
	parameter int NW = 31
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rmq_pkg::ctl_t in_ctl,
	input  logic [SQ-1:0] in_root,
	input  logic [2:0][NW-1:0] in_nq,
	rmq_out_if.source out_ch
);
	localparam int XW = (NW > SQ) ? NW : SQ;
	localparam int W = DATA_WIDTH;

	logic [W-1:0] vq;
	logic [W-1:0] qv [3];
	logic [W-1:0] qx, qy, qz, qw;
	logic valid_q;

	function automatic logic [W-1:0] sat_mag(input logic [XW-1:0] mag, input logic neg);
		logic [XW-1:0] lim;
		logic [W-1:0] res;
		lim = XW'({1'b1, {(W-1){1'b0}}});
		if (neg) begin
			res = (mag >= lim) ? {1'b1, {(W-1){1'b0}}} : W'(-mag[W-1:0]);
		end else begin
			res = (mag >= lim) ? {1'b0, {(W-1){1'b1}}} : mag[W-1:0];
		end
		return res;
	endfunction

	always_comb begin
		vq = sat_mag(XW'(in_root), 1'b0);
		for (int i = 0; i < 3; i++) begin
			qv[i] = (in_root == '0) ? '0 : sat_mag(XW'(in_nq[i]), in_ctl.neg[i]);
		end
		unique case (in_ctl.best)
			rmq_pkg::AXIS_X: begin
				qx = vq; qy = qv[0]; qz = qv[1]; qw = qv[2];
			end
			rmq_pkg::AXIS_Y: begin
				qx = qv[0]; qy = vq; qz = qv[1]; qw = qv[2];
			end
			rmq_pkg::AXIS_Z: begin
				qx = qv[0]; qy = qv[1]; qz = vq; qw = qv[2];
			end
			default: begin
				qx = qv[0]; qy = qv[1]; qz = qv[2]; qw = vq;
			end
		endcase
		if (!in_ctl.ok) begin
			qx = '0; qy = '0; qz = '0; qw = '0;
		end
	end

	assign in_ready = !valid_q || out_ch.ready;
	assign out_ch.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			out_ch.quat_x <= qx;
			out_ch.quat_y <= qy;
			out_ch.quat_z <= qz;
			out_ch.quat_w <= qw;
			out_ch.ok     <= in_ctl.ok;
		end
	end
endmodule

/* hdl/rotation_matrix_to_quaternion_top.sv */
// Top level of the rotation-matrix-to-quaternion pipeline.
// Converts a 3x3 rotation matrix to a quaternion by Shepperd's method in
// fixed point (DATA_WIDTH bits, FRAC_BITS fraction bits). One matrix enters
// per clock unless an output stall holds the pipeline. The stages are a front
// cell, one square-root cell per root bit of the SQ-bit root, where
// SQ = (max(DATA_WIDTH, FRAC_BITS+1) + FRAC_BITS + 2) / 2, one three-lane
// divider cell per quotient bit, and the output register. Each cell holds
// its transaction until the next one has room, so output stalls ripple back
// only as far as the pipeline is full.
module rotation_matrix_to_quaternion_top #(
	parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	rmq_in_if.sink in_ch,
	rmq_out_if.source out_ch
);
	localparam int CW = ((DATA_WIDTH > FRAC_BITS+1) ? DATA_WIDTH : FRAC_BITS+1) + 3;
	localparam int SQ = (CW + FRAC_BITS - 1) / 2;
	localparam int MW = DATA_WIDTH + 1;
	localparam int PW = 3 * MW;
	localparam int NW = MW + FRAC_BITS;

	logic sq_valid [SQ+1];
	logic sq_ready [SQ+1];
	rmq_pkg::ctl_t sq_ctl [SQ+1];
	logic [PW-1:0] sq_pay [SQ+1];
	logic [2*SQ-1:0] sq_nr [SQ+1];
	logic [SQ-1:0] sq_root [SQ+1];
	logic [SQ+1:0] sq_rem [SQ+1];

	logic dv_valid [NW+1];
	logic dv_ready [NW+1];
	rmq_pkg::ctl_t dv_ctl [NW+1];
	logic [SQ-1:0] dv_root [NW+1];
	logic [2:0][NW-1:0] dv_nq [NW+1];
	logic [2:0][SQ+1:0] dv_rem [NW+1];

	rmq_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.out_valid(sq_valid[0]), .out_ready(sq_ready[0]),
		.out_ctl(sq_ctl[0]), .out_mag(sq_pay[0]), .out_nr(sq_nr[0])
	);
	assign sq_root[0] = '0;
	assign sq_rem[0] = '0;

	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		rmq_sqrt_cell #(.SQ(SQ), .PW(PW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(sq_valid[k]), .in_ready(sq_ready[k]),
			.in_ctl(sq_ctl[k]), .in_pay(sq_pay[k]), .in_nr(sq_nr[k]),
			.in_root(sq_root[k]), .in_rem(sq_rem[k]),
			.out_valid(sq_valid[k+1]), .out_ready(sq_ready[k+1]),
			.out_ctl(sq_ctl[k+1]), .out_pay(sq_pay[k+1]), .out_nr(sq_nr[k+1]),
			.out_root(sq_root[k+1]), .out_rem(sq_rem[k+1])
		);
	end

	// hand the root to the divider lanes; numerators are |d| << FRAC_BITS
	assign dv_valid[0] = sq_valid[SQ];
	assign sq_ready[SQ] = dv_ready[0];
	assign dv_ctl[0] = sq_ctl[SQ];
	assign dv_root[0] = sq_root[SQ];
	for (genvar i = 0; i < 3; i++) begin : g_lane
		assign dv_nq[0][i] = {sq_pay[SQ][i*MW +: MW], {FRAC_BITS{1'b0}}};
		assign dv_rem[0][i] = '0;
	end

	for (genvar k = 0; k < NW; k++) begin : g_div
		rmq_div_cell #(.SQ(SQ), .NW(NW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(dv_valid[k]), .in_ready(dv_ready[k]),
			.in_ctl(dv_ctl[k]), .in_root(dv_root[k]),
			.in_nq(dv_nq[k]), .in_rem(dv_rem[k]),
			.out_valid(dv_valid[k+1]), .out_ready(dv_ready[k+1]),
			.out_ctl(dv_ctl[k+1]), .out_root(dv_root[k+1]),
			.out_nq(dv_nq[k+1]), .out_rem(dv_rem[k+1])
		);
	end

	rmq_back #(.DATA_WIDTH(DATA_WIDTH), .SQ(SQ), .NW(NW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(dv_valid[NW]), .in_ready(dv_ready[NW]),
		.in_ctl(dv_ctl[NW]), .in_root(dv_root[NW]), .in_nq(dv_nq[NW]),
		.out_ch(out_ch)
	);
endmodule
